FILE: rtl/core/fufe_pkg.sv
// Shared types and constants for the firmware update frame engine.
// Holds frame geometry, protocol byte codes, result kinds and register map.
// No dependencies.
package fufe_pkg;

    // Frame store geometry
    localparam int FRAME_BYTES = 512;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

    // Positions inside a frame that the decoder looks at (data frame is 262 bytes)
    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 9'd4;
    localparam logic [POS_W-1:0] POS_PAY_LAST  = 9'd259;
    localparam logic [POS_W-1:0] POS_CHECK     = 9'd260;
    localparam logic [POS_W-1:0] POS_TAIL      = 9'd261;
    localparam logic [POS_W-1:0] POS_SCAN_END  = 9'd262;

    // Bytes per programmed flash word
    localparam logic [3:0] WORD_BYTES = 4'd8;
    localparam logic [4:0] LAST_WORD  = 5'd31;

    // Protocol bytes
    localparam logic [7:0] SYNC_BYTE  = 8'h72;
    localparam logic [7:0] CMD_CTRL   = 8'h68;
    localparam logic [7:0] CMD_DATA   = 8'h69;
    localparam logic [7:0] END_BYTE   = 8'h16;
    localparam logic [7:0] ABORT_BYTE = 8'hAA;
    localparam logic [7:0] CODE_NAK   = 8'h03;
    localparam logic [7:0] CODE_START = 8'h02;
    localparam logic [7:0] CODE_ABORT = 8'h01;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TX     = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_PROG64 = 3'd2,
        KIND_PROG16 = 3'd3,
        KIND_RESET  = 3'd4
    } t_kind;

    // Register map (index = paddr[3:2])
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_APP_BASE  = 2'd1;
    localparam logic [1:0] REG_BOOT_FLAG = 2'd2;
    localparam logic [1:0] REG_PPP_LOG2  = 2'd3;

    localparam logic [31:0] APP_BASE_RST  = 32'h0800_3800;
    localparam logic [31:0] BOOT_FLAG_RST = 32'h0800_3400;
    localparam logic [1:0]  PPP_LOG2_RST  = 2'd2;

    typedef struct packed {
        logic        enable;
        logic [31:0] app_base;
        logic [31:0] boot_addr;
        logic [1:0]  ppp_log2;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [63:0] payload;
        logic        last;
    } t_result;

endpackage

FILE: rtl/core/firmware_update_frame_engine_core.sv
// Channel    | Signals                                   | Moves
// -----------+-------------------------------------------+-----------------------------
// in         | i_in_valid / o_in_ready                   | rx byte + frame end flag
// out        | o_out_valid / i_out_ready                 | kind, flash address, payload
// config     | psel, penable, pwrite, paddr, pwdata ...  | APB register write/read
//
// Bytes are taken one per cycle into the frame store while the engine is idle.
// A frame end starts a decode while enabled and until the final data frame is taken:
// a walk over store bytes 0..261 (one read port, one byte a cycle), then for a data
// frame the gathering and programming of each 64-bit word, then the result requests.
// Synchronous active-low reset; the store needs no clearing pass (fill count).
// A stalled sink holds the sequencer at its current request.
// Depends on fufe_pkg, fufe_cfg_regs, fufe_frame_ram, fufe_seq, fufe_out_stage.
module firmware_update_frame_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fufe_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_frame_end,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic [2:0]                  o_kind,
    output logic [31:0]                 o_flash_address,
    output logic [63:0]                 o_payload,
    output logic                        o_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready
);
    import fufe_pkg::*;

    t_cfg                w_cfg;
    logic                w_wr_en;
    logic [FRAME_AW-1:0] w_wr_addr;
    logic [7:0]          w_wr_data;
    logic [FRAME_AW-1:0] w_rd_addr;
    logic [7:0]          w_rd_data;
    logic                w_slot_free;
    logic                w_emit;
    t_result             w_seq_result;
    t_result             w_out_result;

    fufe_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fufe_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    fufe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .i_slot_free (w_slot_free),
        .o_emit      (w_emit),
        .o_result    (w_seq_result)
    );

    fufe_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (w_emit),
        .i_result    (w_seq_result),
        .o_slot_free (w_slot_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_out_result)
    );

    assign o_kind          = w_out_result.kind;
    assign o_flash_address = w_out_result.addr;
    assign o_payload       = w_out_result.payload;
    assign o_last          = w_out_result.last;

endmodule

FILE: rtl/core/fufe_cfg_regs.sv
// APB-style configuration registers of the frame engine.
// Depends on fufe_pkg (register map, reset values, t_cfg).
module fufe_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fufe_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fufe_pkg::t_cfg              o_cfg
);
    import fufe_pkg::*;

    logic        r_enable;
    logic [31:0] r_app_base;
    logic [31:0] r_boot_addr;
    logic [1:0]  r_ppp_log2;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_app_base  <= APP_BASE_RST;
            r_boot_addr <= BOOT_FLAG_RST;
            r_ppp_log2  <= PPP_LOG2_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_APP_BASE:  r_app_base  <= pwdata;
                REG_BOOT_FLAG: r_boot_addr <= pwdata;
                REG_PPP_LOG2:  r_ppp_log2  <= pwdata[1:0];
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_ENABLE:    prdata = {31'd0, r_enable};
            REG_APP_BASE:  prdata = r_app_base;
            REG_BOOT_FLAG: prdata = r_boot_addr;
            REG_PPP_LOG2:  prdata = {30'd0, r_ppp_log2};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{enable: r_enable, app_base: r_app_base,
                     boot_addr: r_boot_addr, ppp_log2: r_ppp_log2};

endmodule

FILE: rtl/core/fufe_frame_ram.sv
// Frame store: one write port, one read port, registered read data.
// Depends on fufe_pkg (FRAME_BYTES, FRAME_AW).
module fufe_frame_ram (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [fufe_pkg::FRAME_AW-1:0] i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    input  logic [fufe_pkg::FRAME_AW-1:0] i_rd_addr,
    output logic [7:0]                    o_rd_data
);
    import fufe_pkg::*;

    logic [7:0] r_mem [FRAME_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/fufe_seq.sv
// Frame sequencer: collects bytes into the frame store, then walks the store
// to decode the closed frame and emits result requests one at a time.
// Depends on fufe_pkg; drives fufe_frame_ram and feeds fufe_out_stage.
module fufe_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fufe_pkg::t_cfg                i_cfg,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_frame_end,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_wr_en,
    output logic [fufe_pkg::FRAME_AW-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic [fufe_pkg::FRAME_AW-1:0] o_rd_addr,
    input  logic [7:0]                    i_rd_data,
    input  logic                          i_slot_free,
    output logic                          o_emit,
    output fufe_pkg::t_result             o_result
);
    import fufe_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_DECIDE  = 9'b000000100,
        S_TX      = 9'b000001000,
        S_ERASE   = 9'b000010000,
        S_PROG_RD = 9'b000100000,
        S_PROG_WR = 9'b001000000,
        S_ECHO    = 9'b010000000,
        S_BOOT    = 9'b100000000
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_len;
    logic [COUNT_W-1:0] n_count;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_dpos;
    logic               r_dvld;
    logic [7:0]         r_b0, r_b1, r_b2, r_b3, r_b4, r_b5, r_chk, r_tail, r_xor;
    logic               r_mode;
    logic [15:0]        r_total;
    logic               r_finished;
    logic [7:0]         r_code;
    logic               r_then_abort;
    logic [2:0]         r_idx;
    logic               r_boot;
    logic [31:0]        r_base;
    logic [4:0]         r_wk;
    logic [3:0]         r_iss;
    logic [2:0]         r_got;
    logic [63:0]        r_word;

    logic               w_accept;
    logic               w_has_room;
    logic [7:0]         w_byte;
    logic               w_hdr_ctrl, w_is_start, w_is_abort, w_is_data, w_xor_ok, w_erase;
    logic [15:0]        w_pkt;
    logic [2:0]         w_page_mask;
    logic [31:0]        w_base;
    logic               w_emit_state;

    // input side
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready & i_in_valid;
    assign w_has_room = (r_count < COUNT_W'(FRAME_BYTES));
    assign n_count    = w_has_room ? r_count + COUNT_W'(1) : r_count;
    assign o_wr_en    = w_accept & w_has_room;
    assign o_wr_addr  = r_count[FRAME_AW-1:0];
    assign o_wr_data  = i_rx_byte;
    assign o_rd_addr  = FRAME_AW'(r_pos);

    // positions past the received length read as zero
    assign w_byte = (COUNT_W'(r_dpos) < r_len) ? i_rd_data : 8'h00;

    // frame classification from the captured bytes
    assign w_pkt      = {r_b2, r_b3};
    assign w_hdr_ctrl = (r_b0 == SYNC_BYTE) && (r_b1 == CMD_CTRL);
    assign w_is_start = w_hdr_ctrl && (r_b4 == END_BYTE);
    assign w_is_abort = w_hdr_ctrl && (r_b2 == ABORT_BYTE) && (r_b5 == END_BYTE);
    assign w_is_data  = (r_b0 == SYNC_BYTE) && (r_b1 == CMD_DATA) && (r_tail == END_BYTE);
    assign w_xor_ok   = (r_xor == r_chk);
    assign w_base     = i_cfg.app_base + (({16'd0, w_pkt} - 32'd1) << 8);

    always_comb begin
        case (i_cfg.ppp_log2)
            2'd0:    w_page_mask = 3'd0;
            2'd1:    w_page_mask = 3'd1;
            2'd2:    w_page_mask = 3'd3;
            default: w_page_mask = 3'd7;
        endcase
    end
    assign w_erase = ((w_pkt[2:0] & w_page_mask) == 3'd1);

    // result build
    assign w_emit_state = (r_state == S_TX) || (r_state == S_ERASE) ||
                          (r_state == S_PROG_WR) || (r_state == S_ECHO) ||
                          (r_state == S_BOOT);
    assign o_emit = w_emit_state & i_slot_free;

    always_comb begin
        o_result = '{kind: KIND_TX, addr: 32'd0, payload: 64'd0, last: 1'b0};
        case (r_state)
            S_TX: begin
                case (r_idx)
                    3'd0:    o_result.payload = {56'd0, SYNC_BYTE};
                    3'd1:    o_result.payload = {56'd0, CMD_CTRL};
                    3'd2:    o_result.payload = {56'd0, r_code};
                    default: o_result.payload = {56'd0, END_BYTE};
                endcase
                o_result.last = (r_idx == 3'd3) && !r_then_abort;
            end
            S_ERASE: begin
                o_result.kind = KIND_ERASE;
                o_result.addr = r_base;
            end
            S_PROG_WR: begin
                o_result.kind    = KIND_PROG64;
                o_result.addr    = r_base + {24'd0, r_wk, 3'd0};
                o_result.payload = r_word;
            end
            S_ECHO: begin
                case (r_idx)
                    3'd0:    o_result.payload = {56'd0, SYNC_BYTE};
                    3'd1:    o_result.payload = {56'd0, CMD_DATA};
                    3'd2:    o_result.payload = {56'd0, r_b2};
                    3'd3:    o_result.payload = {56'd0, r_b3};
                    default: o_result.payload = {56'd0, END_BYTE};
                endcase
                o_result.last = (r_idx == 3'd4) && !r_boot;
            end
            S_BOOT: begin
                case (r_idx)
                    3'd0: begin
                        o_result.kind = KIND_ERASE;
                        o_result.addr = i_cfg.boot_addr;
                    end
                    3'd1: begin
                        o_result.kind = KIND_PROG16;
                        o_result.addr = i_cfg.boot_addr;
                    end
                    default: begin
                        o_result.kind = KIND_RESET;
                        o_result.last = 1'b1;
                    end
                endcase
            end
            default: o_result.last = 1'b0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dvld     <= 1'b0;
            r_mode     <= 1'b0;
            r_total    <= '0;
            r_finished <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_frame_end) begin
                            r_len   <= n_count;
                            r_count <= '0;
                            r_xor   <= 8'h00;
                            r_pos   <= '0;
                            if (i_cfg.enable && !r_finished) begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_count <= n_count;
                        end
                    end
                end

                // one pass over the header, payload XOR and trailer
                S_SCAN: begin
                    r_dvld <= (r_pos != POS_SCAN_END);
                    if (r_pos != POS_SCAN_END) begin
                        r_dpos <= r_pos;
                        r_pos  <= r_pos + POS_W'(1);
                    end
                    if (r_dvld) begin
                        case (r_dpos)
                            9'd0:      r_b0   <= w_byte;
                            9'd1:      r_b1   <= w_byte;
                            9'd2:      r_b2   <= w_byte;
                            9'd3:      r_b3   <= w_byte;
                            POS_CHECK: r_chk  <= w_byte;
                            POS_TAIL:  r_tail <= w_byte;
                            default:   r_tail <= r_tail;
                        endcase
                        if (r_dpos == 9'd4) begin
                            r_b4 <= w_byte;
                        end
                        if (r_dpos == 9'd5) begin
                            r_b5 <= w_byte;
                        end
                        if (r_dpos >= POS_PAY_FIRST && r_dpos <= POS_PAY_LAST) begin
                            r_xor <= r_xor ^ w_byte;
                        end
                        if (r_dpos == POS_TAIL) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE: begin
                    r_idx <= 3'd0;
                    if (!r_mode) begin
                        if (w_is_start) begin
                            r_total      <= w_pkt;
                            r_mode       <= !w_is_abort;
                            r_code       <= CODE_START;
                            r_then_abort <= w_is_abort;
                            r_state      <= S_TX;
                        end else if (w_is_abort) begin
                            r_code       <= CODE_ABORT;
                            r_then_abort <= 1'b0;
                            r_state      <= S_TX;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (w_is_abort) begin
                        r_mode       <= 1'b0;
                        r_code       <= CODE_ABORT;
                        r_then_abort <= 1'b0;
                        r_state      <= S_TX;
                    end else if (w_is_data) begin
                        if (!w_xor_ok) begin
                            r_code       <= CODE_NAK;
                            r_then_abort <= 1'b1;
                            r_state      <= S_TX;
                        end else begin
                            r_base     <= w_base;
                            r_boot     <= (w_pkt == r_total);
                            r_finished <= (w_pkt == r_total);
                            r_pos      <= POS_PAY_FIRST;
                            r_wk       <= '0;
                            r_iss      <= '0;
                            r_got      <= '0;
                            r_state    <= w_erase ? S_ERASE : S_PROG_RD;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end

                // four-byte answer, optionally followed by the abort answer
                S_TX: begin
                    if (i_slot_free) begin
                        if (r_idx == 3'd3) begin
                            r_idx <= 3'd0;
                            if (r_then_abort) begin
                                r_code       <= CODE_ABORT;
                                r_then_abort <= 1'b0;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end

                S_ERASE: begin
                    if (i_slot_free) begin
                        r_state <= S_PROG_RD;
                    end
                end

                // gather eight payload bytes, low byte first
                S_PROG_RD: begin
                    r_dvld <= (r_iss != WORD_BYTES);
                    if (r_iss != WORD_BYTES) begin
                        r_dpos <= r_pos;
                        r_pos  <= r_pos + POS_W'(1);
                        r_iss  <= r_iss + 4'd1;
                    end
                    if (r_dvld) begin
                        r_word <= {w_byte, r_word[63:8]};
                        r_got  <= r_got + 3'd1;
                        if (r_got == 3'd7) begin
                            r_iss   <= '0;
                            r_state <= S_PROG_WR;
                        end
                    end
                end

                S_PROG_WR: begin
                    if (i_slot_free) begin
                        r_wk <= r_wk + 5'd1;
                        if (r_wk == LAST_WORD) begin
                            r_idx   <= 3'd0;
                            r_state <= S_ECHO;
                        end else begin
                            r_state <= S_PROG_RD;
                        end
                    end
                end

                S_ECHO: begin
                    if (i_slot_free) begin
                        if (r_idx == 3'd4) begin
                            r_idx   <= 3'd0;
                            r_state <= r_boot ? S_BOOT : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end

                S_BOOT: begin
                    if (i_slot_free) begin
                        if (r_idx == 3'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(FRAME_BYTES))
        else $error("byte count beyond frame store");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_end) |=> (r_count == '0))
        else $error("byte count not cleared at frame end");

    a_emit_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_state != S_IDLE && r_state != S_SCAN &&
                    r_state != S_DECIDE && r_state != S_PROG_RD))
        else $error("result request outside an emitting state");

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped without reset");

    a_no_input_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_wr_en)
        else $error("frame store written while decoding");
`endif

endmodule

FILE: rtl/core/fufe_out_stage.sv
// Output register for result requests, decoupling the sequencer from the sink.
// Depends on fufe_pkg (t_result).
module fufe_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_emit,
    input  fufe_pkg::t_result   i_result,
    output logic                o_slot_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fufe_pkg::t_result   o_result
);
    import fufe_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_slot_free = !r_valid || i_out_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
